[hdl/i2cee_pkg.sv]
package i2cee_pkg;

  localparam int MEM_BYTES_DEF = 128;
  localparam int BYTE_BITS     = 8;
  localparam int CNT_BITS      = 4;
  localparam int ADDR_STEP     = 2;

  localparam logic ACK  = 1'b0;
  localparam logic NACK = 1'b1;

  typedef logic [BYTE_BITS-1:0] byte_t;
  typedef logic [CNT_BITS-1:0]  bit_cnt_t;

  typedef enum logic [3:0] {
    PH_STANDBY = 4'b0001,
    PH_ADDRESS = 4'b0010,
    PH_READ    = 4'b0100,
    PH_WRITE   = 4'b1000
  } phase_t;

  localparam bit_cnt_t LAST_DATA_BIT = bit_cnt_t'(BYTE_BITS);

endpackage

[hdl/i2cee_sample_if.sv]
interface i2cee_sample_if;
  logic valid;
  logic ready;
  logic scl_present;
  logic scl_level;
  logic sda_present;
  logic sda_level;

  modport source (
    output valid, scl_present, scl_level, sda_present, sda_level,
    input  ready
  );

  modport sink (
    input  valid, scl_present, scl_level, sda_present, sda_level,
    output ready
  );
endinterface

[hdl/i2cee_resp_if.sv]
interface i2cee_resp_if;
  logic valid;
  logic ready;
  logic sda_out;

  modport source (
    output valid, sda_out,
    input  ready
  );

  modport sink (
    input  valid, sda_out,
    output ready
  );
endinterface

[hdl/i2c_serial_eeprom_slave.sv]
// The response bit of each accepted bus sample is registered into the output register, or into the skid.
// Throughput: one sample per cycle; a one-beat skid behind the output register drops ready
// only while both hold a beat. A byte fetch is written to the read register at the edge that
// accepts the beat, in time for the next clock rise.
// Reset (rst, synchronous, active high): standby, lines low, counters and output queue clear,
// write_enable set; storage contents are not cleared.
module i2c_serial_eeprom_slave #(
  parameter int MEM_BYTES = i2cee_pkg::MEM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  i2cee_sample_if.sink          smp,
  i2cee_resp_if.source          rsp
);
  import i2cee_pkg::*;

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [AW-1:0] IDX_MASK = AW'(MEM_BYTES - 1);
  localparam byte_t STEP = byte_t'(ADDR_STEP);

  logic     write_enable;
  phase_t   phase, phase_next;
  logic     clock_line, data_line;
  bit_cnt_t bit_count, bit_count_next;
  byte_t    addr_byte, addr_byte_next;
  byte_t    write_shift, write_shift_next;
  byte_t    read_byte;
  logic     response_bit, response_bit_next;

  byte_t    mem [MEM_BYTES];
  logic     mem_rd, mem_wr;
  logic [AW-1:0] rd_idx, wr_idx;

  logic out_v, out_d, sk_v, sk_d;
  logic acc, pop, result;

  logic new_clk, new_dat, clk_hi, clk_fall, clk_rise, dat_fall, dat_rise, data_bit;
  byte_t addr_inc, rd_shift;

  function automatic logic [AW-1:0] word_idx(input byte_t a);
    return AW'(a[BYTE_BITS-1:1]) & IDX_MASK;
  endfunction

  assign acc       = smp.valid && smp.ready;
  assign pop       = out_v && rsp.ready;
  assign smp.ready = !sk_v;
  assign rsp.valid = out_v;
  assign rsp.sda_out = out_d;

  assign new_clk  = smp.scl_present ? smp.scl_level : clock_line;
  assign new_dat  = smp.sda_present ? smp.sda_level : data_line;
  assign clk_hi   = clock_line && new_clk;
  assign clk_fall = clock_line && !new_clk;
  assign clk_rise = !clock_line && new_clk;
  assign dat_fall = data_line && !new_dat;
  assign dat_rise = !data_line && new_dat;
  assign data_bit = bit_count <= LAST_DATA_BIT;
  assign addr_inc = addr_byte + STEP;
  assign rd_shift = read_byte >> (LAST_DATA_BIT - bit_count);

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    addr_byte_next    = addr_byte;
    write_shift_next  = write_shift;
    response_bit_next = response_bit;
    mem_rd            = 1'b0;
    mem_wr            = 1'b0;
    rd_idx            = word_idx(addr_byte);
    wr_idx            = word_idx(addr_byte);

    if (clk_hi && dat_fall) begin
      bit_count_next = '0;
      phase_next     = PH_ADDRESS;
    end
    if (clk_hi && dat_rise) begin
      bit_count_next = '0;
      phase_next     = PH_STANDBY;
    end

    if (clk_fall) begin
      bit_count_next = (bit_count > LAST_DATA_BIT) ? bit_cnt_t'(1) : bit_count + 1'b1;
    end

    if (clk_rise) begin
      case (phase)
        PH_ADDRESS: begin
          if (data_bit) begin
            addr_byte_next = {addr_byte[BYTE_BITS-2:0], new_dat};
          end else if (addr_byte[0]) begin
            phase_next        = PH_READ;
            mem_rd            = 1'b1;
            response_bit_next = ACK;
          end else begin
            phase_next        = PH_WRITE;
            response_bit_next = ACK;
          end
        end
        PH_READ: begin
          if (data_bit) begin
            response_bit_next = rd_shift[0];
          end else if (new_dat == ACK) begin
            addr_byte_next    = addr_inc;
            rd_idx            = word_idx(addr_inc);
            mem_rd            = 1'b1;
            response_bit_next = ACK;
          end else begin
            phase_next = PH_STANDBY;
          end
        end
        PH_WRITE: begin
          if (data_bit) begin
            write_shift_next = {write_shift[BYTE_BITS-2:0], new_dat};
          end else begin
            mem_wr            = write_enable;
            response_bit_next = write_enable ? ACK : NACK;
            addr_byte_next    = addr_inc;
          end
        end
        default: begin
        end
      endcase
    end

    result = (phase_next == PH_STANDBY) ? new_dat : response_bit_next;
  end

  always_ff @(posedge clk) begin
    if (acc && mem_wr) begin
      mem[wr_idx] <= write_shift;
    end
    if (acc && mem_rd) begin
      read_byte <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      write_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STANDBY;
      clock_line   <= 1'b0;
      data_line    <= 1'b0;
      bit_count    <= '0;
      addr_byte    <= '0;
      write_shift  <= '0;
      response_bit <= ACK;
    end else if (acc) begin
      phase        <= phase_next;
      clock_line   <= new_clk;
      data_line    <= new_dat;
      bit_count    <= bit_count_next;
      addr_byte    <= addr_byte_next;
      write_shift  <= write_shift_next;
      response_bit <= response_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (acc) begin
      if (!out_v || pop) begin
        out_d <= result;
        out_v <= 1'b1;
      end else begin
        sk_d <= result;
        sk_v <= 1'b1;
      end
    end else if (pop) begin
      if (sk_v) begin
        out_d <= sk_d;
        sk_v  <= 1'b0;
      end else begin
        out_v <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sk_v |-> out_v)
    else $error("skid beat held without an output beat");

  a_beat_offered: assert property (@(posedge clk) disable iff (rst) acc |=> out_v)
    else $error("accepted sample left no response beat");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= LAST_DATA_BIT + 1'b1)
    else $error("bit counter past acknowledge slot");

  a_no_store_disabled: assert property (@(posedge clk) disable iff (rst)
    (acc && mem_wr) |-> write_enable)
    else $error("store while writing is disabled");
`endif

endmodule

[tb/i2c_serial_eeprom_slave_test.sv]
module i2c_serial_eeprom_slave_test;
  import i2cee_pkg::*;

  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam logic RD = 1'b1;
  localparam logic WR = 1'b0;

  typedef struct packed {
    logic scl_p;
    logic scl_l;
    logic sda_p;
    logic sda_l;
  } sample_t;

  typedef struct packed {
    phase_t ph;
    logic clk_l;
    logic dat_l;
    bit_cnt_t cnt;
    byte_t addr;
    byte_t wsh;
    byte_t rbyte;
    logic resp;
    logic sda_out;
    logic unsafe;
    logic [MEM_BYTES-1:0] written;
    logic [MEM_BYTES-1:0][BYTE_BITS-1:0] mem;
  } eeprom_state_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  i2cee_sample_if smp();
  i2cee_resp_if rsp();

  i2c_serial_eeprom_slave #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .smp(smp),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t bus_samples[$];
  logic sda_expected[$];
  eeprom_state_t eeprom;
  eeprom_state_t gen_eeprom;
  logic store_enabled;
  logic gen_store_enabled;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned send_gap;
  int unsigned resp_stall;
  logic calm = 1'b0;

  function automatic eeprom_state_t eeprom_next(eeprom_state_t s, sample_t x, logic wr_ok);
    logic nclk;
    logic ndat;
    logic hi;
    logic fall;
    logic rise;
    logic fetch;
    phase_t prev;
    int idx;
    prev = s.ph;
    fetch = 1'b0;
    s.unsafe = 1'b0;
    nclk = x.scl_p ? x.scl_l : s.clk_l;
    ndat = x.sda_p ? x.sda_l : s.dat_l;
    hi = s.clk_l & nclk;
    fall = s.clk_l & ~nclk;
    rise = ~s.clk_l & nclk;
    if (hi && s.dat_l && !ndat) begin
      s.cnt = '0;
      s.ph = PH_ADDRESS;
    end
    if (hi && !s.dat_l && ndat) begin
      s.cnt = '0;
      s.ph = PH_STANDBY;
    end
    s.clk_l = nclk;
    s.dat_l = ndat;
    if (fall) s.cnt = (s.cnt > LAST_DATA_BIT) ? bit_cnt_t'(1) : s.cnt + 1'b1;
    if (rise) begin
      case (prev)
        PH_ADDRESS: begin
          if (s.cnt <= LAST_DATA_BIT) begin
            s.addr = {s.addr[BYTE_BITS-2:0], ndat};
          end else if (s.addr[0] == RD) begin
            s.ph = PH_READ;
            fetch = 1'b1;
          end else begin
            s.ph = PH_WRITE;
            s.resp = ACK;
          end
        end
        PH_READ: begin
          if (s.cnt <= LAST_DATA_BIT) begin
            s.resp = (s.cnt == 0) ? 1'b0 : s.rbyte[BYTE_BITS - int'(s.cnt)];
          end else if (ndat == ACK) begin
            s.addr = s.addr + byte_t'(ADDR_STEP);
            fetch = 1'b1;
          end else begin
            s.ph = PH_STANDBY;
          end
        end
        PH_WRITE: begin
          if (s.cnt <= LAST_DATA_BIT) begin
            s.wsh = {s.wsh[BYTE_BITS-2:0], ndat};
          end else begin
            idx = (int'(s.addr) >> 1) & (MEM_BYTES - 1);
            if (wr_ok) begin
              s.mem[idx] = s.wsh;
              s.written[idx] = 1'b1;
              s.resp = ACK;
            end else begin
              s.resp = NACK;
            end
            s.addr = s.addr + byte_t'(ADDR_STEP);
          end
        end
        default: ;
      endcase
    end
    if (fetch) begin
      idx = (int'(s.addr) >> 1) & (MEM_BYTES - 1);
      if (!s.written[idx]) s.unsafe = 1'b1;
      s.rbyte = s.mem[idx];
      s.resp = ACK;
    end
    // a read address parked in its acknowledge slot fetches on the next rise
    idx = (int'(s.addr) >> 1) & (MEM_BYTES - 1);
    if (s.ph == PH_ADDRESS && !s.clk_l && s.cnt > LAST_DATA_BIT && s.addr[0] == RD &&
        !s.written[idx]) s.unsafe = 1'b1;
    s.sda_out = (s.ph == PH_STANDBY) ? s.dat_l : s.resp;
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_written();
    int s;
    int i;
    s = $urandom_range(0, MEM_BYTES - 1);
    for (i = 0; i < MEM_BYTES; i++) begin
      if (gen_eeprom.written[(s + i) % MEM_BYTES]) return (s + i) % MEM_BYTES;
    end
    return s;
  endfunction

  task automatic emit(input logic scl_p, input logic scl_l, input logic sda_p,
                      input logic sda_l);
    sample_t x;
    eeprom_state_t t;
    x = {scl_p, scl_l, sda_p, sda_l};
    t = eeprom_next(gen_eeprom, x, gen_store_enabled);
    if (t.unsafe) begin
      x.sda_p = 1'b1;
      x.sda_l = 1'b1;
      t = eeprom_next(gen_eeprom, x, gen_store_enabled);
    end
    if (t.unsafe) begin
      x = {1'b0, scl_l, 1'b1, ~gen_eeprom.dat_l};
      t = eeprom_next(gen_eeprom, x, gen_store_enabled);
    end
    gen_eeprom = t;
    bus_samples.push_back(x);
    n_queued++;
  endtask

  task automatic put_bit(input logic b);
    if ($urandom_range(0, 9) == 0) begin
      emit(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
    end
    case ($urandom_range(0, 2))
      0: begin
        emit(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        emit(1'b0, 1'($urandom_range(0, 1)), 1'b1, b);
        emit(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
      end
      1: begin
        emit(1'b1, 1'b0, 1'b1, b);
        emit(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
      end
      default: begin
        emit(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        emit(1'b1, 1'b1, 1'b1, b);
      end
    endcase
  endtask

  task automatic send_byte(input byte_t v, input logic ack_level);
    int i;
    for (i = BYTE_BITS - 1; i >= 0; i--) put_bit(v[i]);
    put_bit(ack_level);
  endtask

  task automatic bus_start();
    if (!gen_eeprom.clk_l) begin
      emit(1'b0, 1'b0, 1'b1, 1'b1);
      emit(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
    end else if (!gen_eeprom.dat_l) begin
      emit(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
    end
    emit(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
  endtask

  task automatic bus_stop();
    emit(1'b1, 1'b0, 1'b1, 1'b0);
    emit(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
    emit(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
  endtask

  task automatic write_txn(input int word, input int n);
    int k;
    bus_start();
    send_byte({word[BYTE_BITS-2:0], WR}, 1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) put_bit(1'($urandom_range(0, 1)));
        return;
      end
      send_byte(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 4) != 0) bus_stop();
  endtask

  task automatic read_txn(input int word, input int n);
    int k;
    logic last;
    bus_start();
    send_byte({word[BYTE_BITS-2:0], RD}, 1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      repeat (BYTE_BITS) put_bit(1'($urandom_range(0, 1)));
      last = (k == n - 1) || !gen_eeprom.written[(word + k + 1) % MEM_BYTES];
      put_bit(last ? NACK : ACK);
      if (last) break;
    end
    if ($urandom_range(0, 6) != 0) bus_stop();
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    stop_at = n_queued + budget;
    while (n_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 40) write_txn($urandom_range(0, MEM_BYTES - 1), $urandom_range(1, 3));
      else if (r < 75) read_txn(pick_written(), $urandom_range(1, 3));
      else repeat ($urandom_range(4, 16)) emit(1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (!(n_accepted == n_queued && sda_expected.size() == 0)) @(posedge clk);
  endtask

  task automatic cfg_write(input logic v);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    store_enabled = v;
    gen_store_enabled = v;
  endtask

  always @(posedge clk) begin
    sample_t nxt;
    if (rst) begin
      smp.valid <= 1'b0;
      send_gap <= 0;
    end else if (!smp.valid || smp.ready) begin
      if (send_gap > 0) begin
        smp.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (bus_samples.size() > 0) begin
        nxt = bus_samples.pop_front();
        smp.valid <= 1'b1;
        smp.scl_present <= nxt.scl_p;
        smp.scl_level <= nxt.scl_l;
        smp.sda_present <= nxt.sda_p;
        smp.sda_level <= nxt.sda_l;
        send_gap <= pick_gap();
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      resp_stall <= 0;
    end else if (resp_stall > 0) begin
      rsp.ready <= 1'b0;
      resp_stall <= resp_stall - 1;
    end else begin
      rsp.ready <= 1'b1;
      resp_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    logic got;
    logic want;
    got = 1'b0;
    if (!rst) begin
      if (smp.valid && smp.ready) begin
        eeprom = eeprom_next(eeprom,
                             {smp.scl_present, smp.scl_level, smp.sda_present, smp.sda_level},
                             store_enabled);
        sda_expected.push_back(eeprom.sda_out);
        n_accepted++;
        got = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        got = 1'b1;
        if (sda_expected.size() == 0) begin
          $display("%0t: sda_out expected none actual %b", $time, rsp.sda_out);
          errors++;
        end else begin
          want = sda_expected.pop_front();
          if (rsp.sda_out !== want) begin
            $display("%0t: sda_out expected %b actual %b", $time, want, rsp.sda_out);
            errors++;
          end
        end
      end
      idle_cycles <= got ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int p;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    smp.valid = 1'b0;
    smp.scl_present = 1'b0;
    smp.scl_level = 1'b0;
    smp.sda_present = 1'b0;
    smp.sda_level = 1'b0;
    rsp.ready = 1'b0;
    eeprom = '0;
    eeprom.ph = PH_STANDBY;
    gen_eeprom = eeprom;
    store_enabled = 1'b1;
    gen_store_enabled = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cfg_write(1'b1);
    emit(1'b0, 1'b1, 1'b0, 1'b1);
    bus_start();
    send_byte({7'd127, WR}, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    bus_stop();
    bus_start();
    send_byte({7'd64, WR}, 1'b0);
    send_byte(8'hA5, 1'b0);
    bus_start();
    repeat (3) put_bit(1'b1);
    bus_stop();
    emit(1'b0, 1'b0, 1'b0, 1'b0);
    read_txn(127, 2);
    read_txn(64, 1);

    cfg_write(1'b0);
    bus_start();
    send_byte({7'd1, WR}, 1'b1);
    send_byte(8'h3C, 1'b1);
    bus_stop();
    read_txn(0, 1);

    for (p = 0; p < 4; p++) begin
      cfg_write(p[0] ? 1'b0 : 1'b1);
      calm = (p == 2);
      random_traffic(12);
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/i2cee_pkg.sv
hdl/i2cee_sample_if.sv
hdl/i2cee_resp_if.sv
hdl/i2c_serial_eeprom_slave.sv
tb/i2c_serial_eeprom_slave_test.sv
